// ===== hdl/prf_pkg.sv =====
// Shared constants and types for the pose reference filter.
// Used by the lane, normalizer and top-level modules; no dependencies.
`default_nettype none
package prf_pkg;

    localparam int AXES          = 7;
    localparam int LIN_AXES      = 3;
    localparam int QUAT_AXES     = 4;
    localparam int QUAT_W_AXIS   = 3;
    localparam int FRAC_BITS_DEF = 16;

    localparam int REF_LIN_W  = 32;
    localparam int REF_QUAT_W = 18;
    localparam int POS_W      = 32;
    localparam int VEL_W      = 21;
    localparam int GAIN_W     = 20;
    localparam int DT_W       = 17;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int AXIS_W     = 3;
    localparam int S_DATA_W   = 168;
    localparam int M_DATA_W   = 56;

    localparam logic [39:0] W2_CAP    = 40'd16777215;
    localparam logic [39:0] DW_CAP    = 40'd33554431;
    localparam logic [19:0] LIMIT_CAP = 20'd655360;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DAMP_LIN  = 3'd0,
        REG_FREQ_LIN  = 3'd1,
        REG_DAMP_ANG  = 3'd2,
        REG_FREQ_ANG  = 3'd3,
        REG_STEP      = 3'd4,
        REG_LIMIT_LIN = 3'd5,
        REG_LIMIT_ANG = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0] damp;
        logic [GAIN_W-1:0] freq;
        logic [GAIN_W-1:0] limit;
        logic [DT_W-1:0]   dt;
    } lane_cfg_t;

endpackage
`default_nettype wire

// ===== hdl/pose_reference_filter_unit.sv =====
// Pose reference filter: seven filter lanes, quaternion normalizer and
// result serializer. Depends on prf_pkg, prf_lane and prf_norm.
//
// Usage: a pose setpoint request enters on the s_ stream (x, y, z, qw, qx,
// qy, qz packed from bit 0 up). Seven axis results leave on the m_ stream in
// axis order; m_tlast marks axis 6. Gains must be written on the cfg_ port
// only while the block is idle; the block itself does not enforce this. A
// write to an index of 7 is dropped. Per item: the lane pipelines, then the
// normalizer, which skips its steps for a zero quaternion and otherwise
// runs a prescale, squaring, 32 square-root steps and FRAC_BITS+2 divide steps.
// The seven results then leave at one per cycle from an output register
// while m_tready is high; the block takes one setpoint at a time and
// s_tready stays low until the last result is taken.
// When the receiver stalls, the current result holds on m_tdata.
// After reset the state is zero with the quaternion at (1, 0, 0, 0) and the
// gain registers hold their defaults.
`default_nettype none
module pose_reference_filter_unit #(
    parameter int FRAC_BITS = prf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // ref_x[31:0], ref_y[63:32], ref_z[95:64], ref_qw[113:96],
    // ref_qx[131:114], ref_qy[149:132], ref_qz[167:150]
    input  wire logic [prf_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // axis[2:0], smooth_position[34:3], smooth_velocity[55:35]
    output logic [prf_pkg::M_DATA_W-1:0]           m_tdata,
    output logic                                   m_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic [prf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [prf_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import prf_pkg::*;

    localparam logic [63:0] ONE_L   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] RST_DL  = 3 * ONE_L / 2;
    localparam logic [63:0] RST_FL  = (4 * ONE_L + 5) / 10;
    localparam logic [63:0] RST_DT  = (ONE_L + 5) / 10;
    localparam logic [63:0] RST_LA  = (ONE_L + 3) / 6;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LANE = 4'b0010,
        ST_NORM = 4'b0100,
        ST_SEND = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic       out_last_reg, out_last_next;

    logic [GAIN_W-1:0] damp_lin_reg, freq_lin_reg, damp_ang_reg, freq_ang_reg;
    logic [GAIN_W-1:0] lim_lin_reg, lim_ang_reg;
    logic [DT_W-1:0]   dt_reg;

    logic               accept;
    logic               norm_start;
    logic               commit;
    logic [AXES-1:0]    lane_done;
    logic signed [31:0] lane_pn  [AXES];
    logic signed [31:0] lane_pos [AXES];
    logic signed [20:0] lane_vel [AXES];
    logic signed [31:0] lane_wd  [AXES];
    logic signed [31:0] norm_q   [QUAT_AXES];
    logic signed [31:0] quat_pn  [QUAT_AXES];
    logic               norm_done;
    lane_cfg_t          cfg_lin, cfg_ang;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign norm_start = (state_reg == ST_LANE) && lane_done[0];
    assign commit     = (state_reg == ST_NORM) && norm_done;

    assign cfg_lin = '{damp: damp_lin_reg, freq: freq_lin_reg, limit: lim_lin_reg, dt: dt_reg};
    assign cfg_ang = '{damp: damp_ang_reg, freq: freq_ang_reg, limit: lim_ang_reg, dt: dt_reg};

    for (genvar i = 0; i < AXES; i++) begin : g_lane
        localparam logic [31:0] PI = (i == QUAT_W_AXIS) ? ONE_L[31:0] : 32'd0;
        logic signed [31:0] ref_i;
        if (i < LIN_AXES) begin : g_lin
            assign ref_i      = $signed(s_tdata[REF_LIN_W*i +: REF_LIN_W]);
            assign lane_wd[i] = lane_pn[i];
        end else begin : g_ang
            assign ref_i = 32'($signed(
                s_tdata[REF_LIN_W*LIN_AXES + REF_QUAT_W*(i-LIN_AXES) +: REF_QUAT_W]));
            assign lane_wd[i]           = norm_q[i-LIN_AXES];
            assign quat_pn[i-LIN_AXES]  = lane_pn[i];
        end
        prf_lane #(
            .FRAC_BITS (FRAC_BITS),
            .POS_INIT  (PI)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .start     (accept),
            .cfg       ((i < LIN_AXES) ? cfg_lin : cfg_ang),
            .ref_in    (ref_i),
            .pos_wr    (commit),
            .pos_wdata (lane_wd[i]),
            .done      (lane_done[i]),
            .pn        (lane_pn[i]),
            .pos       (lane_pos[i]),
            .vel       (lane_vel[i])
        );
    end

    prf_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .q_in    (quat_pn),
        .done    (norm_done),
        .q_out   (norm_q)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LANE;
                end
            end
            ST_LANE: begin
                if (lane_done[0]) begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if (norm_done) begin
                    state_next     = ST_SEND;
                    cnt_next       = 3'd0;
                    out_valid_next = 1'b0;
                end
            end
            ST_SEND: begin
                // Load the next axis, or go idle after the last, once the held result is gone.
                if (!out_valid_reg || m_tready) begin
                    if (cnt_reg == 3'(AXES)) begin
                        out_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end else begin
                        out_valid_next = 1'b1;
                        out_data_next  = {lane_vel[cnt_reg], lane_pos[cnt_reg], cnt_reg};
                        out_last_next  = (cnt_reg == 3'(AXES - 1));
                        cnt_next       = cnt_reg + 3'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damp_lin_reg <= RST_DL[GAIN_W-1:0];
            freq_lin_reg <= RST_FL[GAIN_W-1:0];
            damp_ang_reg <= ONE_L[GAIN_W-1:0];
            freq_ang_reg <= ONE_L[GAIN_W-1:0];
            dt_reg       <= RST_DT[DT_W-1:0];
            lim_lin_reg  <= ONE_L[GAIN_W-1:0];
            lim_ang_reg  <= RST_LA[GAIN_W-1:0];
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DAMP_LIN:  damp_lin_reg <= cfg_wr_data;
                REG_FREQ_LIN:  freq_lin_reg <= cfg_wr_data;
                REG_DAMP_ANG:  damp_ang_reg <= cfg_wr_data;
                REG_FREQ_ANG:  freq_ang_reg <= cfg_wr_data;
                REG_STEP:      dt_reg       <= cfg_wr_data[DT_W-1:0];
                REG_LIMIT_LIN: lim_lin_reg  <= cfg_wr_data;
                REG_LIMIT_ANG: lim_ang_reg  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while results pending");
    a_last_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[AXIS_W-1:0] == 3'(AXES - 1)))
        else $error("last flag on wrong axis");
    a_lanes_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (|lane_done) |-> (&lane_done))
        else $error("lanes out of step");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("ready stayed high after accept");
    a_commit_once: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (state_reg == ST_SEND) && !m_tvalid)
        else $error("commit without entering send");
`endif

endmodule
`default_nettype wire

// ===== hdl/prf_lane.sv =====
// One filter lane: holds the position and velocity of one axis and runs
// the Euler step through a five-stage pipeline. Depends on prf_pkg.
`default_nettype none
module prf_lane #(
    parameter int          FRAC_BITS = prf_pkg::FRAC_BITS_DEF,
    parameter logic [31:0] POS_INIT  = 32'd0
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire prf_pkg::lane_cfg_t  cfg,
    input  wire logic signed [31:0]  ref_in,
    input  wire logic                pos_wr,
    input  wire logic signed [31:0]  pos_wdata,
    output logic                     done,
    output logic signed [31:0]       pn,
    output logic signed [31:0]       pos,
    output logic signed [20:0]       vel
);
    import prf_pkg::*;

    localparam logic signed [39:0] P_MAX   = 40'sh007FFFFFFF;
    localparam logic signed [39:0] P_MIN   = 40'shFF80000000;
    localparam logic signed [58:0] ACC_MAX = 59'sd4398046511103;
    localparam logic signed [58:0] ACC_MIN = -59'sd4398046511103;

    logic [4:0] stg_reg, stg_next;
    logic signed [31:0] pos_reg;
    logic signed [20:0] vel_reg;

    logic [39:0]        wsq_reg, dwp_reg;
    logic signed [32:0] diff_reg;
    logic signed [38:0] pd_reg;
    logic signed [57:0] m1_reg;
    logic signed [46:0] m2_reg;
    logic signed [31:0] pn_reg;
    logic signed [42:0] acc_reg;
    logic signed [60:0] m3_reg;

    logic [39:0]        w2_full, dw_full;
    logic [23:0]        w2;
    logic [24:0]        dw;
    logic signed [39:0] psum;
    logic signed [31:0] pn_next;
    logic signed [58:0] accd, acc_sh;
    logic signed [42:0] acc_next;
    logic [19:0]        lim;
    logic signed [61:0] vsum, lim_s;
    logic signed [20:0] vn;

    assign stg_next = {stg_reg[3:0], start};

    always_comb begin
        w2_full = wsq_reg >> FRAC_BITS;
        dw_full = dwp_reg >> (FRAC_BITS - 1);
        w2 = (w2_full > W2_CAP) ? W2_CAP[23:0] : w2_full[23:0];
        dw = (dw_full > DW_CAP) ? DW_CAP[24:0] : dw_full[24:0];

        psum = 40'(pos_reg) + 40'(pd_reg >>> FRAC_BITS);
        if (psum > P_MAX) begin
            pn_next = P_MAX[31:0];
        end else if (psum < P_MIN) begin
            pn_next = P_MIN[31:0];
        end else begin
            pn_next = psum[31:0];
        end

        accd   = 59'(m1_reg) - 59'(m2_reg);
        acc_sh = accd >>> FRAC_BITS;
        if (acc_sh > ACC_MAX) begin
            acc_next = ACC_MAX[42:0];
        end else if (acc_sh < ACC_MIN) begin
            acc_next = ACC_MIN[42:0];
        end else begin
            acc_next = acc_sh[42:0];
        end

        lim   = (cfg.limit > LIMIT_CAP) ? LIMIT_CAP : cfg.limit;
        lim_s = 62'($signed({1'b0, lim}));
        vsum  = 62'(m3_reg >>> FRAC_BITS) + 62'(vel_reg);
        if (vsum > lim_s) begin
            vn = lim_s[20:0];
        end else if (vsum < -lim_s) begin
            vn = 21'(-lim_s);
        end else begin
            vn = vsum[20:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_reg <= '0;
            pos_reg <= POS_INIT;
            vel_reg <= '0;
        end else begin
            stg_reg <= stg_next;
            if (pos_wr) begin
                pos_reg <= pos_wdata;
            end
            if (stg_reg[3]) begin
                vel_reg <= vn;
            end
        end
    end

    // Datapath: each stage holds a product or a saturated sum.
    always_ff @(posedge aclk) begin
        if (start) begin
            wsq_reg  <= {20'd0, cfg.freq} * {20'd0, cfg.freq};
            dwp_reg  <= {20'd0, cfg.damp} * {20'd0, cfg.freq};
            diff_reg <= 33'(ref_in) - 33'(pos_reg);
            pd_reg   <= $signed({1'b0, cfg.dt}) * vel_reg;
        end
        if (stg_reg[0]) begin
            m1_reg <= $signed({1'b0, w2}) * diff_reg;
            m2_reg <= $signed({1'b0, dw}) * vel_reg;
            pn_reg <= pn_next;
        end
        if (stg_reg[1]) begin
            acc_reg <= acc_next;
        end
        if (stg_reg[2]) begin
            m3_reg <= $signed({1'b0, cfg.dt}) * acc_reg;
        end
    end

    assign done = stg_reg[4];
    assign pn   = pn_reg;
    assign pos  = pos_reg;
    assign vel  = vel_reg;

endmodule
`default_nettype wire

// ===== hdl/prf_norm.sv =====
// Quaternion normalizer: power-of-two prescale, sum of squares, bit-serial
// integer square root and four parallel restoring dividers. Depends on prf_pkg.
`default_nettype none
module prf_norm #(
    parameter int FRAC_BITS = prf_pkg::FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] q_in  [prf_pkg::QUAT_AXES],
    output logic                    done,
    output logic signed [31:0]      q_out [prf_pkg::QUAT_AXES]
);
    import prf_pkg::*;

    localparam int QW = FRAC_BITS + 2;
    localparam int CW = $clog2(QW);
    localparam logic [CW-1:0] DIV_TOP = CW'(QW - 1);

    typedef enum logic [4:0] {
        N_IDLE  = 5'b00001,
        N_SCALE = 5'b00010,
        N_SQ    = 5'b00100,
        N_ROOT  = 5'b01000,
        N_DIV   = 5'b10000
    } nstate_t;

    nstate_t state_reg, state_next;
    logic    done_reg, done_next;

    logic [31:0]        mag_reg [QUAT_AXES];
    logic               neg_reg [QUAT_AXES];
    logic [31:0]        mx_reg;
    logic [1:0]         k_reg;
    logic [61:0]        sum_reg;
    logic [63:0]        v_reg, r_reg, b_reg;
    logic [4:0]         rcnt_reg;
    logic [31:0]        n_reg;
    logic [63:0]        rem_reg [QUAT_AXES];
    logic [QW-1:0]      quo_reg [QUAT_AXES];
    logic [CW-1:0]      dcnt_reg;
    logic signed [31:0] qo_reg  [QUAT_AXES];

    logic [31:0] mag_in [QUAT_AXES];
    logic [31:0] mx_in;
    logic [63:0] rb, r_step, v_step;
    logic        take;
    logic [63:0] dsub;

    always_comb begin
        mx_in = '0;
        for (int k = 0; k < QUAT_AXES; k++) begin
            mag_in[k] = q_in[k][31] ? (~q_in[k] + 32'd1) : q_in[k];
            if (mag_in[k] > mx_in) begin
                mx_in = mag_in[k];
            end
        end
        rb     = r_reg + b_reg;
        take   = (v_reg >= rb);
        v_step = take ? (v_reg - rb) : v_reg;
        r_step = take ? ((r_reg >> 1) + b_reg) : (r_reg >> 1);
        dsub   = 64'(n_reg) << dcnt_reg;
    end

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            N_IDLE: begin
                if (start) begin
                    if (mx_in == 32'd0) begin
                        done_next = 1'b1;
                    end else begin
                        state_next = N_SCALE;
                    end
                end
            end
            N_SCALE: begin
                if (mx_reg[31:29] == 3'b001) begin
                    state_next = N_SQ;
                end
            end
            N_SQ: begin
                if (k_reg == 2'd3) begin
                    state_next = N_ROOT;
                end
            end
            N_ROOT: begin
                if (rcnt_reg == 5'd0) begin
                    state_next = N_DIV;
                end
            end
            N_DIV: begin
                if (dcnt_reg == '0) begin
                    state_next = N_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            N_IDLE: begin
                if (start) begin
                    for (int k = 0; k < QUAT_AXES; k++) begin
                        mag_reg[k] <= mag_in[k];
                        neg_reg[k] <= q_in[k][31];
                        qo_reg[k]  <= q_in[k];
                    end
                    mx_reg <= mx_in;
                end
            end
            N_SCALE: begin
                // Bring the largest magnitude into [2^29, 2^30) one bit a cycle.
                if (mx_reg[31:29] == 3'b000) begin
                    mx_reg <= mx_reg << 1;
                    for (int k = 0; k < QUAT_AXES; k++) begin
                        mag_reg[k] <= mag_reg[k] << 1;
                    end
                end else if (mx_reg[31:30] != 2'b00) begin
                    mx_reg <= mx_reg >> 1;
                    for (int k = 0; k < QUAT_AXES; k++) begin
                        mag_reg[k] <= mag_reg[k] >> 1;
                    end
                end else begin
                    k_reg   <= 2'd0;
                    sum_reg <= '0;
                end
            end
            N_SQ: begin
                sum_reg <= sum_reg + 62'(mag_reg[k_reg][29:0]) * 62'(mag_reg[k_reg][29:0]);
                k_reg   <= k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    v_reg    <= 64'(sum_reg + 62'(mag_reg[k_reg][29:0]) *
                                              62'(mag_reg[k_reg][29:0]));
                    r_reg    <= '0;
                    b_reg    <= 64'd1 << 62;
                    rcnt_reg <= 5'd31;
                end
            end
            N_ROOT: begin
                v_reg    <= v_step;
                r_reg    <= r_step;
                b_reg    <= b_reg >> 2;
                rcnt_reg <= rcnt_reg - 5'd1;
                if (rcnt_reg == 5'd0) begin
                    n_reg    <= r_step[31:0];
                    dcnt_reg <= DIV_TOP;
                    for (int k = 0; k < QUAT_AXES; k++) begin
                        // Round to nearest: add half the divisor before dividing.
                        rem_reg[k] <= (64'(mag_reg[k]) << FRAC_BITS) + (r_step >> 1);
                        quo_reg[k] <= '0;
                    end
                end
            end
            N_DIV: begin
                dcnt_reg <= dcnt_reg - CW'(1);
                for (int k = 0; k < QUAT_AXES; k++) begin
                    if (rem_reg[k] >= dsub) begin
                        rem_reg[k]           <= rem_reg[k] - dsub;
                        quo_reg[k][dcnt_reg] <= 1'b1;
                    end
                end
                if (dcnt_reg == '0) begin
                    for (int k = 0; k < QUAT_AXES; k++) begin
                        if (rem_reg[k] >= dsub) begin
                            qo_reg[k] <= neg_reg[k] ? -$signed(32'(quo_reg[k] | QW'(1)))
                                                    : $signed(32'(quo_reg[k] | QW'(1)));
                        end else begin
                            qo_reg[k] <= neg_reg[k] ? -$signed(32'(quo_reg[k]))
                                                    : $signed(32'(quo_reg[k]));
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign done  = done_reg;
    assign q_out = qo_reg;

endmodule
`default_nettype wire

// ===== bench/pose_reference_filter_unit_test.sv =====
// Testbench for pose_reference_filter_unit: drives pose setpoint requests,
// predicts the seven axis results per request and checks them in order.
// Depends on prf_pkg and the pose_reference_filter_unit RTL.
`timescale 1ns / 1ps
module pose_reference_filter_unit_test;
    import prf_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] BAD_INDEX = 3'd7;
    localparam longint                FRAC      = FRAC_BITS_DEF;

    typedef struct {
        logic [2:0]  axis;
        logic [31:0] pos;
        logic [20:0] vel;
        logic        last;
    } axis_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    axis_result_t expected_axes[$];
    longint       gain_reg[7];
    longint       pos_state[7];
    longint       vel_state[7];
    int           mismatches;
    bit           send_quiet;
    bit           recv_quiet;
    bit           hold_req;

    pose_reference_filter_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic longint sat(input longint x, input longint lo, input longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint int_root(input longint val);
        bit [63:0] v, r, b;
        v = val;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // One Euler step on every axis, then renormalize the quaternion part.
    function automatic void advance_filter(input logic [S_DATA_W-1:0] d);
        longint target[7], pn[7], vn[7], mag[4];
        longint damp, freq, lim, w2, dw, acc, dt, mx, sum, n, q;
        axis_result_t res;
        target[0] = longint'($signed(d[31:0]));
        target[1] = longint'($signed(d[63:32]));
        target[2] = longint'($signed(d[95:64]));
        target[3] = longint'($signed(d[113:96]));
        target[4] = longint'($signed(d[131:114]));
        target[5] = longint'($signed(d[149:132]));
        target[6] = longint'($signed(d[167:150]));
        dt = gain_reg[REG_STEP];
        for (int i = 0; i < 7; i++) begin
            damp = (i < 3) ? gain_reg[REG_DAMP_LIN] : gain_reg[REG_DAMP_ANG];
            freq = (i < 3) ? gain_reg[REG_FREQ_LIN] : gain_reg[REG_FREQ_ANG];
            lim  = (i < 3) ? gain_reg[REG_LIMIT_LIN] : gain_reg[REG_LIMIT_ANG];
            if (lim > 655360) lim = 655360;
            w2 = (freq * freq) >>> FRAC;
            if (w2 > 64'd16777215) w2 = 16777215;
            dw = (2 * damp * freq) >>> FRAC;
            if (dw > 64'd33554431) dw = 33554431;
            acc = (w2 * (target[i] - pos_state[i]) - dw * vel_state[i]) >>> FRAC;
            acc = sat(acc, -((64'sd1 <<< 42) - 1), (64'sd1 <<< 42) - 1);
            pn[i] = sat(pos_state[i] + ((dt * vel_state[i]) >>> FRAC),
                        -64'sd2147483648, 64'sd2147483647);
            vn[i] = sat(vel_state[i] + ((dt * acc) >>> FRAC), -lim, lim);
        end
        mx = 0;
        for (int k = 0; k < 4; k++) begin
            mag[k] = pn[3 + k] < 0 ? -pn[3 + k] : pn[3 + k];
            if (mag[k] > mx) mx = mag[k];
        end
        if (mx != 0) begin
            while (mx < (64'sd1 <<< 29)) begin
                mx = mx <<< 1;
                for (int k = 0; k < 4; k++) mag[k] = mag[k] <<< 1;
            end
            while (mx >= (64'sd1 <<< 30)) begin
                mx = mx >>> 1;
                for (int k = 0; k < 4; k++) mag[k] = mag[k] >>> 1;
            end
            sum = 0;
            for (int k = 0; k < 4; k++) sum += mag[k] * mag[k];
            n = int_root(sum);
            if (n != 0) begin
                for (int k = 0; k < 4; k++) begin
                    q = ((mag[k] <<< FRAC) + (n >>> 1)) / n;
                    pn[3 + k] = pn[3 + k] < 0 ? -q : q;
                end
            end
        end
        for (int i = 0; i < 7; i++) begin
            pos_state[i] = pn[i];
            vel_state[i] = vn[i];
            res.axis = i[2:0];
            res.pos  = pn[i][31:0];
            res.vel  = vn[i][20:0];
            res.last = (i == 6);
            expected_axes = {expected_axes, res};
        end
    endfunction

    // Offer one setpoint request; valid stays high until the next call or a rest.
    task automatic send_setpoint(input logic [31:0] x, y, z, input logic [17:0] qw, qx, qy, qz);
        int gap;
        gap = (!send_quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {qz, qy, qx, qw, z, y, x};
        do @(posedge aclk); while (!s_tready);
        advance_filter({qz, qy, qx, qw, z, y, x});
    endtask

    task automatic sender_rest();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold until every expected result has come and the block has drained.
    task automatic drain();
        sender_rest();
        while (expected_axes.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [19:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        if (idx < 7) gain_reg[idx] = (idx == REG_STEP) ? longint'(val[16:0]) : longint'(val);
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [19:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 20'd0;
            1: return 20'd655360;
            2: return 20'hFFFFF;
            3: return 20'($urandom_range(0, 655360));
            default: return 20'($urandom_range(0, 196608));
        endcase
    endfunction

    task automatic random_settings();
        drain();
        write_reg(REG_DAMP_LIN, pick_gain());
        write_reg(REG_FREQ_LIN, pick_gain());
        write_reg(REG_DAMP_ANG, pick_gain());
        write_reg(REG_FREQ_ANG, pick_gain());
        case ($urandom_range(0, 4))
            0: write_reg(REG_STEP, 20'd65536);
            1: write_reg(REG_STEP, 20'd1);
            2: write_reg(REG_STEP, 20'($urandom_range(0, 20'hFFFFF)));
            default: write_reg(REG_STEP, 20'($urandom_range(1, 65536)));
        endcase
        write_reg(REG_LIMIT_LIN, pick_gain());
        write_reg(REG_LIMIT_ANG, pick_gain());
        end_writes();
    endtask

    task automatic random_setpoint();
        logic [31:0] p[3];
        logic [17:0] q[4];
        for (int i = 0; i < 3; i++)
            p[i] = ($urandom_range(0, 2) == 0) ? $urandom() : $signed($urandom_range(0, 1310720)) - 655360;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 7))
                0: q[k] = 18'($urandom());
                1: q[k] = 18'd0;
                default: q[k] = 18'($signed($urandom_range(0, 131072)) - 65536);
            endcase
        end
        send_setpoint(p[0], p[1], p[2], q[0], q[1], q[2], q[3]);
    endtask

    task automatic test_field_extremes();
        send_setpoint(32'h7FFFFFFF, 32'h80000000, 32'h0, 18'h10000, 18'h30000, 18'h0, 18'h0);
        send_setpoint(32'hFFFFFFFF, 32'h0, 32'h7FFFFFFF, 18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000);
        send_setpoint(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 18'h30000, 18'h10000, 18'h30000, 18'h10000);
        send_setpoint(32'h0, 32'h0, 32'h0, 18'h10000, 18'h0, 18'h0, 18'h0);
    endtask

    task automatic test_zero_quaternion();
        drain();
        write_reg(REG_STEP, 20'd65536);
        write_reg(REG_FREQ_ANG, 20'd0);
        end_writes();
        // send zero quaternion setpoints with the angular frequency at zero
        send_setpoint(32'h0, 32'h0, 32'h0, 18'h0, 18'h0, 18'h0, 18'h0);
        send_setpoint(32'h0, 32'h0, 32'h0, 18'h0, 18'h0, 18'h0, 18'h0);
    endtask

    task automatic test_zero_step_and_limits();
        drain();
        write_reg(REG_STEP, 20'd0);
        write_reg(REG_LIMIT_LIN, 20'd0);
        write_reg(REG_LIMIT_ANG, 20'hFFFFF);
        write_reg(BAD_INDEX, 20'd12345);
        end_writes();
        send_setpoint(32'h00640000, 32'hFF9C0000, 32'h1, 18'h08000, 18'h38000, 18'h04000, 18'h0);
        send_setpoint(32'h12345678, 32'h9ABCDEF0, 32'h0, 18'h10000, 18'h10000, 18'h10000, 18'h10000);
        drain();
        write_reg(REG_STEP, 20'd65536);
        write_reg(REG_DAMP_LIN, 20'hFFFFF);
        write_reg(REG_FREQ_LIN, 20'hFFFFF);
        end_writes();
        for (int i = 0; i < 4; i++)
            send_setpoint(32'h7FFFFFFF, 32'h80000000, 32'h0, 18'h2ABCD, 18'h15432, 18'h0, 18'h1);
    endtask

    // Drive the linear axes toward the 32-bit bounds at full speed and step.
    task automatic test_position_saturation();
        drain();
        write_reg(REG_STEP, 20'd65536);
        write_reg(REG_DAMP_LIN, 20'd0);
        write_reg(REG_FREQ_LIN, 20'd65536);
        write_reg(REG_LIMIT_LIN, 20'd655360);
        end_writes();
        send_quiet = 1;
        recv_quiet = 1;
        for (int i = 0; i < 8; i++)
            send_setpoint(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 18'h10000, 18'h0, 18'h0, 18'h0);
        send_quiet = 0;
        recv_quiet = 0;
    endtask

    task automatic test_backpressure();
        drain();
        hold_req = 1;
        for (int i = 0; i < 4; i++) random_setpoint();
        drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 9; ph++) begin
            random_settings();
            if (ph == 8) begin
                send_quiet = 1;
                recv_quiet = 1;
            end
            for (int i = 0; i < 40; i++) random_setpoint();
        end
    endtask

    // Receiver: random stalls, a long hold-off on request, none when quiet.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_req = 0;
            end else if (!recv_quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        axis_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_axes.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tlast=%b", $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = expected_axes.pop_front();
                if (m_tdata[2:0] !== want.axis) begin
                    $display("%0t: axis expected %0d actual %0d", $time, want.axis, m_tdata[2:0]);
                    mismatches++;
                end
                if (m_tdata[34:3] !== want.pos) begin
                    $display("%0t: position axis %0d expected %h actual %h",
                             $time, want.axis, want.pos, m_tdata[34:3]);
                    mismatches++;
                end
                if (m_tdata[55:35] !== want.vel) begin
                    $display("%0t: velocity axis %0d expected %h actual %h",
                             $time, want.axis, want.vel, m_tdata[55:35]);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last axis %0d expected %b actual %b",
                             $time, want.axis, want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        mismatches  = 0;
        send_quiet  = 0;
        recv_quiet  = 0;
        hold_req    = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        gain_reg    = '{98304, 26214, 65536, 65536, 6554, 65536, 10923};
        pos_state   = '{0, 0, 0, 65536, 0, 0, 0};
        vel_state   = '{0, 0, 0, 0, 0, 0, 0};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_zero_quaternion();
        test_zero_step_and_limits();
        test_position_saturation();
        test_backpressure();
        test_random_phases();

        drain();
        if (mismatches == 0 && expected_axes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
